>>> hw/rtl/fdl_pkg.sv
// ----------------------------------------------------------------------------
// fdl_pkg
// Shared constants and types of the fractional delay line with feedback.
// ----------------------------------------------------------------------------
package fdl_pkg;

  localparam int DEPTH_DEF   = 65536;
  localparam int FRAC_BITS   = 28;
  localparam int SAMPLE_W    = 24;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_INDEX_W = 3;

  localparam logic [31:0] CHORUS_BASE = 32'd268435;
  localparam logic [19:0] CHORUS_SPAN = 20'd536871;
  // Reciprocal of five in Q.22, exact for the feedback gain range.
  localparam logic [19:0] RECIP5      = 20'd838861;
  localparam logic [16:0] UNITY_Q16   = 17'd65536;
  localparam logic signed [23:0] Q23_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] Q23_MIN = -24'sh800000;

  // Soft clip divider sizes.
  localparam int DIV_NW = 55;
  localparam int DIV_DW = 30;
  localparam int DIV_QW = 26;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MODE     = 3'd0,
    CFG_RATE     = 3'd1,
    CFG_TIME     = 3'd2,
    CFG_FEEDBACK = 3'd3,
    CFG_WET      = 3'd4,
    CFG_SMOOTH   = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> hw/rtl/fdl_mem.sv
// ----------------------------------------------------------------------------
// fdl_mem
// Single-port-write, single-port-read sample store with registered read data.
// ----------------------------------------------------------------------------
module fdl_mem #(
  parameter int DEPTH = fdl_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [AW-1:0]                       waddr,
  input  logic signed [fdl_pkg::SAMPLE_W-1:0] wdata,
  input  logic [AW-1:0]                       raddr,
  output logic signed [fdl_pkg::SAMPLE_W-1:0] rdata
);

  logic signed [fdl_pkg::SAMPLE_W-1:0] ram [DEPTH];
  logic signed [fdl_pkg::SAMPLE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      ram[waddr] <= wdata;
    end
    rdata_r <= ram[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/fdl_div.sv
// ----------------------------------------------------------------------------
// fdl_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fdl_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [fdl_pkg::DIV_NW-1:0]    num,
  input  logic [fdl_pkg::DIV_DW-1:0]    den,
  output logic [fdl_pkg::DIV_QW-1:0]    quo,
  output fdl_pkg::div_stat_t            stat
);

  localparam int NW = fdl_pkg::DIV_NW;
  localparam int DW = fdl_pkg::DIV_DW;
  localparam int QW = fdl_pkg::DIV_QW;
  localparam int CW = $clog2(QW + 1);

  logic [DW:0]   rem_r;
  logic [QW-1:0] nsh_r;
  logic [QW-1:0] q_r;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   trial;
  logic          fits;

  // The caller guarantees the quotient fits in QW bits, so the top part of
  // the numerator is already below the divisor.
  assign trial = {rem_r[DW-1:0], nsh_r[QW-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= (DW+1)'(num[NW-1:QW]);
        nsh_r  <= num[QW-1:0];
        den_r  <= den;
        q_r    <= '0;
        cnt_r  <= CW'(QW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= fits ? trial - {1'b0, den_r} : trial;
        q_r   <= {q_r[QW-2:0], fits};
        nsh_r <= {nsh_r[QW-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quo       = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

>>> hw/rtl/fractional_delay_line_feedback.sv
// ----------------------------------------------------------------------------
// fractional_delay_line_feedback
// Fractional delay line with linear interpolation, soft-clipped feedback and
// a chorus mode, built around one sample memory and a shared multiplier.
//
//   channel | direction | payload (low bit first)
//   in_     | slave     | tdata: audio_in[23:0], modulation[39:24]
//   out_    | master    | tdata: audio_out[23:0]
//   cfg_    | write     | index 0..5, data up to 24 bits
//
// An item is worked in sixteen steps through one shared multiplier, including
// two reads of the single memory read port, then waits on the bit-serial
// soft-clip divider (26 quotient bits) and ends with two mix steps. The next
// item is taken only after the result of the last one is loaded into out_.
// After reset a clearing pass zeroes the memory; no item is taken during it.
// Reset is synchronous, active low. A result waiting on out_ holds the
// sequencer at its last step only.
// ----------------------------------------------------------------------------
module fractional_delay_line_feedback #(
  parameter int DEPTH = fdl_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [39:0]                        in_tdata,   // audio_in, modulation
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [23:0]                        out_tdata,  // audio_out
  input  logic                               cfg_we,
  input  logic [fdl_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [fdl_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int FB = fdl_pkg::FRAC_BITS;
  localparam logic [63:0] CAP  = 64'(DEPTH - 2) << FB;
  localparam logic [63:0] SPAN = 64'(DEPTH) << FB;
  localparam logic [24:0] CLIP_LIM = 25'd25165824;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_TGT, S_SMUL, S_SUPD, S_DMUL, S_POS, S_RD1, S_RD0,
    S_INTP, S_SAMP, S_GAIN, S_FB, S_XS, S_SQ, S_X2, S_NUM, S_DIVGO, S_DIVW,
    S_MIX2, S_OUT
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic        mode_r;
  logic [17:0] rate_r;
  logic [23:0] time_r;
  logic [16:0] fbk_r;
  logic [16:0] wet_r;
  logic [15:0] coeff_r;

  // Item state and working registers.
  logic [AW-1:0]        clr_r;
  logic [AW-1:0]        wp_r;
  logic signed [23:0]   fed_r;
  logic [31:0]          sm_r;
  logic signed [23:0]   x_r;
  logic [15:0]          mod_r;
  logic [AW-1:0]        i1_r;
  logic [AW-1:0]        i0_r;
  logic [FB-1:0]        mu_r;
  logic signed [23:0]   y1_r;
  logic signed [23:0]   y0_r;
  logic signed [23:0]   samp_r;
  logic [16:0]          gain_r;
  logic [24:0]          a_r;
  logic                 neg_r;
  logic [26:0]          x2_r;
  logic signed [63:0]   prod_r;
  logic signed [63:0]   acc_r;
  logic                 out_valid_r;
  logic [23:0]          out_data_r;

  // Shared multiplier operands.
  logic signed [33:0] mul_a;
  logic signed [29:0] mul_b;
  logic signed [63:0] prod_nxt;

  // Memory port.
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic signed [23:0] mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic signed [23:0] mem_rdata;

  // Divider.
  logic                          div_start;
  logic [fdl_pkg::DIV_NW-1:0]    div_num;
  logic [fdl_pkg::DIV_DW-1:0]    div_den;
  logic [fdl_pkg::DIV_QW-1:0]    div_quo;
  fdl_pkg::div_stat_t            div_stat;

  // Combinational helpers.
  logic [16:0]        wet_c;
  logic [16:0]        fbk_c;
  logic [31:0]        target;
  logic signed [32:0] tdiff;
  logic [63:0]        dly;
  logic [63:0]        pos0;
  logic [63:0]        pos1;
  logic [63:0]        i1w;
  logic [AW-1:0]      i1_c;
  logic signed [24:0] ydiff;
  logic signed [63:0] sm_sum;
  logic signed [25:0] xs;
  logic signed [63:0] mix;
  logic signed [23:0] mix_sat;
  logic signed [23:0] clip_q;
  logic signed [23:0] wr_val;
  logic               ld_out;

  assign wet_c = (wet_r > fdl_pkg::UNITY_Q16) ? fdl_pkg::UNITY_Q16 : wet_r;
  assign fbk_c = (fbk_r > fdl_pkg::UNITY_Q16) ? fdl_pkg::UNITY_Q16 : fbk_r;

  always_comb begin
    target = mode_r ? fdl_pkg::CHORUS_BASE + 32'(prod_r >>> 15)
                    : {time_r, 8'd0};
    tdiff  = $signed({1'b0, target}) - $signed({1'b0, sm_r});
    sm_sum = $signed({32'd0, sm_r}) + (prod_r >>> 16);

    dly  = (prod_r > $signed(CAP)) ? CAP : prod_r;
    pos0 = 64'(wp_r) << FB;
    pos1 = (pos0 < dly) ? pos0 + SPAN - dly : pos0 - dly;
    i1w  = pos1 >> FB;
    if (i1w >= 64'(DEPTH)) begin
      i1w = i1w - 64'(DEPTH);
    end
    i1_c = i1w[AW-1:0];

    ydiff = 25'(y1_r) - 25'(mem_rdata);
    xs    = 26'(x_r) + 26'(prod_r >>> 16);

    mix = (acc_r + prod_r) >>> 16;
    if (mix > 64'(fdl_pkg::Q23_MAX)) begin
      mix_sat = fdl_pkg::Q23_MAX;
    end else if (mix < 64'(fdl_pkg::Q23_MIN)) begin
      mix_sat = fdl_pkg::Q23_MIN;
    end else begin
      mix_sat = mix[23:0];
    end

    // Full scale is reached at three and above, and the quotient saturates.
    if (a_r >= CLIP_LIM || div_quo > 26'(fdl_pkg::Q23_MAX)) begin
      clip_q = fdl_pkg::Q23_MAX;
    end else begin
      clip_q = div_quo[23:0];
    end
    wr_val = neg_r ? -clip_q : clip_q;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_TGT:   begin
        mul_a = $signed(34'(fdl_pkg::CHORUS_SPAN));
        mul_b = $signed(30'(mod_r ^ 16'h8000));
      end
      S_SMUL:  begin
        mul_a = 34'(tdiff);
        mul_b = $signed(30'(coeff_r));
      end
      S_DMUL:  begin
        mul_a = $signed(34'(sm_r));
        mul_b = $signed(30'(rate_r));
      end
      S_INTP:  begin
        mul_a = 34'(ydiff);
        mul_b = $signed(30'(mu_r));
      end
      S_SAMP:  begin
        mul_a = $signed(34'(20'(fbk_c) * 20'd6 + 20'd2));
        mul_b = $signed(30'(fdl_pkg::RECIP5));
      end
      S_FB:    begin
        mul_a = 34'(fed_r);
        mul_b = $signed(30'(gain_r));
      end
      S_SQ:    begin
        mul_a = $signed(34'(a_r));
        mul_b = $signed(30'(a_r));
      end
      S_NUM:   begin
        mul_a = $signed(34'(a_r));
        mul_b = $signed(30'd226492416 + 30'(x2_r));
      end
      S_DIVW:  begin
        mul_a = 34'(x_r);
        mul_b = $signed(30'(fdl_pkg::UNITY_Q16 - wet_c));
      end
      // The wet product is kept alive while the result waits.
      S_MIX2, S_OUT: begin
        mul_a = 34'(samp_r);
        mul_b = $signed(30'(wet_c));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = 64'(mul_a) * 64'(mul_b);

  assign div_start = (state_r == S_DIVGO);
  assign div_num   = prod_r[fdl_pkg::DIV_NW-1:0];
  assign div_den   = 30'd226492416 + 30'(x2_r) * 30'd9;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wp_r;
    mem_wdata = wr_val;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
      end
      S_DIVW:  mem_we = div_stat.done;
      default: mem_we = 1'b0;
    endcase
    mem_raddr = (state_r == S_RD0) ? i0_r : i1_r;
  end

  assign ld_out    = (state_r == S_OUT) && (!out_valid_r || out_tready);
  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      wp_r        <= '0;
      fed_r       <= '0;
      sm_r        <= '0;
      out_valid_r <= 1'b0;
      mode_r      <= 1'b0;
      rate_r      <= 18'd48000;
      time_r      <= '0;
      fbk_r       <= '0;
      wet_r       <= 17'd32768;
      coeff_r     <= 16'd131;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fdl_pkg::CFG_MODE:     mode_r  <= cfg_wdata[0];
          fdl_pkg::CFG_RATE:     rate_r  <= cfg_wdata[17:0];
          fdl_pkg::CFG_TIME:     time_r  <= cfg_wdata[23:0];
          fdl_pkg::CFG_FEEDBACK: fbk_r   <= cfg_wdata[16:0];
          fdl_pkg::CFG_WET:      wet_r   <= cfg_wdata[16:0];
          fdl_pkg::CFG_SMOOTH:   coeff_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (ld_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      prod_r <= prod_nxt;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_tvalid) begin
            x_r     <= in_tdata[23:0];
            mod_r   <= in_tdata[39:24];
            state_r <= S_TGT;
          end
        end
        S_TGT:  state_r <= S_SMUL;
        S_SMUL: state_r <= S_SUPD;
        S_SUPD: begin
          sm_r    <= sm_sum[31:0];
          state_r <= S_DMUL;
        end
        S_DMUL: state_r <= S_POS;
        S_POS: begin
          i1_r    <= i1_c;
          i0_r    <= (i1_c == '0) ? AW'(DEPTH - 1) : i1_c - 1'b1;
          mu_r    <= pos1[FB-1:0];
          state_r <= S_RD1;
        end
        S_RD1:  state_r <= S_RD0;
        S_RD0: begin
          y1_r    <= mem_rdata;
          state_r <= S_INTP;
        end
        S_INTP: begin
          y0_r    <= mem_rdata;
          state_r <= S_SAMP;
        end
        S_SAMP: begin
          samp_r  <= y0_r + 24'(prod_r >>> FB);
          state_r <= S_GAIN;
        end
        S_GAIN: begin
          gain_r  <= mode_r ? 17'd0 : prod_r[38:22];
          state_r <= S_FB;
        end
        S_FB:   state_r <= S_XS;
        S_XS: begin
          neg_r   <= xs[25];
          a_r     <= xs[25] ? 25'(-xs) : 25'(xs);
          state_r <= S_SQ;
        end
        S_SQ:   state_r <= S_X2;
        S_X2: begin
          x2_r    <= prod_r[49:23];
          state_r <= S_NUM;
        end
        S_NUM:  state_r <= S_DIVGO;
        S_DIVGO: state_r <= S_DIVW;
        S_DIVW: begin
          if (div_stat.done) begin
            fed_r   <= samp_r;
            state_r <= S_MIX2;
          end
        end
        S_MIX2: begin
          acc_r   <= prod_r;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (ld_out) begin
            out_data_r  <= mix_sat;
            wp_r        <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  fdl_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  fdl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .stat  (div_stat)
  );

  // One item at a time: nothing is taken in the cycle after an acceptance.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second item taken while one is in work");

  // The write position advances by one, wrapping, with each result.
  a_wp_step: assert property (@(posedge clk) disable iff (!rst_n)
    ld_out |=> (wp_r == (($past(wp_r) == AW'(DEPTH - 1)) ? '0 : $past(wp_r) + 1'b1)))
    else $error("write position did not advance with the result");

  // The divider is never restarted while it is working.
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

endmodule
